[rtl/ldq_pkg.sv]
// Shared constants, codes and types for the linear array deque.
package ldq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int CAP_W         = 5;
    localparam int ACT_W         = 2;
    localparam int STAT_W        = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request codes
    localparam logic [ACT_W-1:0] ACT_INS_FRONT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_INS_REAR  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_DEL_REAR  = 2'd3;

    // Result codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_REFUSED = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDER   = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;     // perform the presented request this edge
        logic cfg_we;   // load the capacity register
    } ctl_cmd_t;

endpackage

[rtl/ldq_ctrl.sv]
// Request sequencer for the linear array deque.
module ldq_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             cfg_valid,
    output logic             busy,
    output logic             done,
    output logic             cfg_ready,
    output ldq_pkg::ctl_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = start ? S_RESP : S_IDLE;
            S_RESP:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = (state_reg == S_RESP);
    assign cfg_ready  = (state_reg == S_IDLE);
    assign cmd.exec   = (state_reg == S_IDLE) && start;
    assign cmd.cfg_we = (state_reg == S_IDLE) && cfg_valid;

endmodule

[rtl/ldq_dp.sv]
// Datapath: slot memory, front/rear indices, capacity and result registers.
module ldq_dp
#(
    parameter int DEPTH = ldq_pkg::DEPTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ldq_pkg::ctl_cmd_t          cmd,
    input  logic [ldq_pkg::ACT_W-1:0]  action,
    input  logic signed [ldq_pkg::DATA_W-1:0] item,
    input  logic [ldq_pkg::CAP_W-1:0]  cfg_data,
    output logic [ldq_pkg::STAT_W-1:0] status,
    output logic signed [ldq_pkg::DATA_W-1:0] removed_item
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CW    = (IDX_W + 1 > ldq_pkg::CAP_W) ? IDX_W + 1 : ldq_pkg::CAP_W;

    logic [ldq_pkg::DATA_W-1:0] mem [DEPTH];

    logic [IDX_W-1:0] front_reg, front_next;
    logic [IDX_W-1:0] rear_reg,  rear_next;
    logic             empty_reg, empty_next;
    logic [ldq_pkg::CAP_W-1:0] cap_reg;

    logic [ldq_pkg::STAT_W-1:0] status_reg, status_next;
    logic                       del_ok_reg, del_ok_next;
    logic [ldq_pkg::DATA_W-1:0] rd_data_reg;

    logic             we;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;

    logic [CW-1:0] cap_ext;
    logic [CW-1:0] cap_eff;
    logic [CW-1:0] rear_inc;
    logic          rear_full;
    logic          same_slot;

    // Capacity clamped to 1..DEPTH
    assign cap_ext  = CW'(cap_reg);
    assign cap_eff  = (cap_ext == '0) ? CW'(1) :
                      (cap_ext > CW'(DEPTH)) ? CW'(DEPTH) : cap_ext;
    assign rear_inc = CW'(rear_reg) + CW'(1);
    assign rear_full = (rear_inc >= cap_eff);
    assign same_slot = (front_reg == rear_reg);

    always_comb
    begin
        front_next  = front_reg;
        rear_next   = rear_reg;
        empty_next  = empty_reg;
        we          = 1'b0;
        wr_addr     = front_reg;
        rd_addr     = front_reg;
        status_next = ldq_pkg::STAT_OK;
        del_ok_next = 1'b0;
        case (action)
            ldq_pkg::ACT_INS_FRONT:
            begin
                if (empty_reg)
                begin
                    we         = 1'b1;
                    wr_addr    = '0;
                    front_next = '0;
                    rear_next  = '0;
                    empty_next = 1'b0;
                end
                else if (front_reg != '0)
                begin
                    we         = 1'b1;
                    wr_addr    = front_reg - IDX_W'(1);
                    front_next = front_reg - IDX_W'(1);
                end
                else
                begin
                    status_next = ldq_pkg::STAT_REFUSED;
                end
            end
            ldq_pkg::ACT_DEL_FRONT:
            begin
                if (empty_reg)
                begin
                    status_next = ldq_pkg::STAT_UNDER;
                end
                else
                begin
                    del_ok_next = 1'b1;
                    rd_addr     = front_reg;
                    if (same_slot)
                    begin
                        empty_next = 1'b1;
                        front_next = '0;
                        rear_next  = '0;
                    end
                    else
                    begin
                        front_next = front_reg + IDX_W'(1);
                    end
                end
            end
            ldq_pkg::ACT_INS_REAR:
            begin
                if (empty_reg)
                begin
                    we         = 1'b1;
                    wr_addr    = '0;
                    front_next = '0;
                    rear_next  = '0;
                    empty_next = 1'b0;
                end
                else if (rear_full)
                begin
                    status_next = ldq_pkg::STAT_REFUSED;
                end
                else
                begin
                    we        = 1'b1;
                    wr_addr   = rear_reg + IDX_W'(1);
                    rear_next = rear_reg + IDX_W'(1);
                end
            end
            ldq_pkg::ACT_DEL_REAR:
            begin
                if (empty_reg)
                begin
                    status_next = ldq_pkg::STAT_UNDER;
                end
                else
                begin
                    del_ok_next = 1'b1;
                    rd_addr     = rear_reg;
                    if (same_slot)
                    begin
                        empty_next = 1'b1;
                        front_next = '0;
                        rear_next  = '0;
                    end
                    else
                    begin
                        rear_next = rear_reg - IDX_W'(1);
                    end
                end
            end
            default:
            begin
                status_next = ldq_pkg::STAT_OK;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            rear_reg  <= '0;
            empty_reg <= 1'b1;
            cap_reg   <= ldq_pkg::CAP_RESET;
        end
        else
        begin
            if (cmd.exec)
            begin
                front_reg <= front_next;
                rear_reg  <= rear_next;
                empty_reg <= empty_next;
            end
            if (cmd.cfg_we)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // Slot memory, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.exec && we)
        begin
            mem[wr_addr] <= item;
        end
        if (cmd.exec)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg <= status_next;
            del_ok_reg <= del_ok_next;
        end
    end

    assign status       = status_reg;
    assign removed_item = del_ok_reg ? rd_data_reg : '0;

endmodule

[rtl/linear_array_deque.sv]
// Top level of the linear array deque: controller, datapath and checks.
//
//  channel   ports                              handshake
//  -------   --------------------------------   ----------------------------
//  request   start, action, item                start && !busy at clk edge
//  result    done, status, removed_item         done, one cycle, no stall
//  config    cfg_valid, cfg_ready, cfg_data     cfg_valid && cfg_ready
//
// For each request, the accept edge updates the indices, writes the slot
// and captures the memory read; the next cycle shows the result with done
// high while busy holds off the next request. The result waits on the
// registered read port of the slot memory.
// rst_n clears the indices to an empty queue and capacity to 16; slot
// contents stay undefined until written. Results cannot be stalled.
// Capacity is written only while idle (cfg_ready is low during a result).
module linear_array_deque
#(
    parameter int DEPTH = ldq_pkg::DEPTH_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // request
    input  logic                        start,
    output logic                        busy,
    input  logic [ldq_pkg::ACT_W-1:0]   action,
    input  logic signed [ldq_pkg::DATA_W-1:0] item,
    // result
    output logic                        done,
    output logic [ldq_pkg::STAT_W-1:0]  status,
    output logic signed [ldq_pkg::DATA_W-1:0] removed_item,
    // capacity register
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ldq_pkg::CAP_W-1:0]   cfg_data
);

    ldq_pkg::ctl_cmd_t cmd;

    // Sequencer: accepts requests and config writes, strobes results
    ldq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_valid (cfg_valid),
        .busy      (busy),
        .done      (done),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    // Indices, slot memory and the result registers
    ldq_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .action       (action),
        .item         (item),
        .cfg_data     (cfg_data),
        .status       (status),
        .removed_item (removed_item)
    );

    // Every accepted request produces a result on the next cycle
    a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("accepted request gave no result");

    // Each done strobe is followed by done low
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe lasted more than one cycle");

    // A failed request returns a zero word
    a_removed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ldq_pkg::STAT_OK) |-> (removed_item == '0))
        else $error("failed request returned a word");

    // No capacity write while a result is on the ports
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !cfg_ready)
        else $error("config accepted during a result");

endmodule

[tb/linear_array_deque_test.sv]
// Self-checking testbench for the linear array deque: directed and random requests.
module linear_array_deque_test;

    localparam int DEPTH       = ldq_pkg::DEPTH_DEFAULT;
    // Watchdog limit, set with a wide margin over the slowest legal run.
    localparam int CYCLE_LIMIT = 200000;

    // One predicted result: status code and the word a delete hands back.
    typedef struct {
        logic [ldq_pkg::STAT_W-1:0] status;
        logic [ldq_pkg::DATA_W-1:0] removed;
    } deque_result_t;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              start     = 1'b0;
    logic [ldq_pkg::ACT_W-1:0]         action    = ldq_pkg::ACT_INS_FRONT;
    logic signed [ldq_pkg::DATA_W-1:0] item      = '0;
    logic                              cfg_valid = 1'b0;
    logic [ldq_pkg::CAP_W-1:0]         cfg_data  = '0;
    logic                              busy;
    logic                              done;
    logic [ldq_pkg::STAT_W-1:0]        status;
    logic signed [ldq_pkg::DATA_W-1:0] removed_item;
    logic                              cfg_ready;

    // Shadow of the deque: slot contents, indices and the capacity register.
    logic [ldq_pkg::DATA_W-1:0] shadow_slots [DEPTH];
    int                         shadow_front    = 0;
    int                         shadow_rear     = -1;
    logic [ldq_pkg::CAP_W-1:0]  shadow_capacity = ldq_pkg::CAP_RESET;

    // Results predicted at request accept, oldest first.
    deque_result_t expected_results [$];

    int mismatch_count  = 0;
    int cycle_count     = 0;
    int sender_idle_pct = 15;

    linear_array_deque #(.DEPTH(DEPTH)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .item         (item),
        .done         (done),
        .status       (status),
        .removed_item (removed_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Capacity as the deque sees it: zero acts as one, anything above the
    // built depth saturates.
    function automatic int usable_capacity();
        int cap;
        cap = shadow_capacity;
        if (cap == 0)
            cap = 1;
        if (cap > DEPTH)
            cap = DEPTH;
        return cap;
    endfunction

    function automatic bit shadow_empty();
        return shadow_rear == -1 || shadow_front == shadow_rear + 1;
    endfunction

    // Once front passes rear the queue is empty; park indices at 0 / -1.
    function automatic void park_if_empty();
        if (shadow_front > shadow_rear)
        begin
            shadow_front = 0;
            shadow_rear  = -1;
        end
    endfunction

    // Apply one request to the shadow deque and return the result it yields.
    function automatic deque_result_t predict_deque_op(
        input logic [ldq_pkg::ACT_W-1:0]  op,
        input logic [ldq_pkg::DATA_W-1:0] word);
        deque_result_t r;
        r.status  = ldq_pkg::STAT_OK;
        r.removed = '0;
        case (op)
            ldq_pkg::ACT_INS_FRONT:
            begin
                // Front insert goes to slot 0 of an empty queue, or one below
                // front when there is room; otherwise it is refused.
                if (shadow_front == 0 && shadow_rear == -1)
                begin
                    shadow_rear     = 0;
                    shadow_slots[0] = word;
                end
                else if (shadow_front > 0)
                begin
                    shadow_front--;
                    shadow_slots[shadow_front] = word;
                end
                else
                    r.status = ldq_pkg::STAT_REFUSED;
            end
            ldq_pkg::ACT_DEL_FRONT:
            begin
                if (shadow_empty())
                    r.status = ldq_pkg::STAT_UNDER;
                else
                begin
                    r.removed = shadow_slots[shadow_front];
                    shadow_front++;
                    park_if_empty();
                end
            end
            ldq_pkg::ACT_INS_REAR:
            begin
                // Rear insert stops at capacity minus one, even when the
                // capacity was lowered below the current fill.
                if (shadow_rear + 1 >= usable_capacity())
                    r.status = ldq_pkg::STAT_REFUSED;
                else
                begin
                    shadow_rear++;
                    shadow_slots[shadow_rear] = word;
                end
            end
            default:
            begin
                if (shadow_empty())
                    r.status = ldq_pkg::STAT_UNDER;
                else
                begin
                    r.removed = shadow_slots[shadow_rear];
                    shadow_rear--;
                    park_if_empty();
                end
            end
        endcase
        return r;
    endfunction

    // Data words lean on the sign extremes, zero and all ones.
    function automatic logic [ldq_pkg::DATA_W-1:0] random_word();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [ldq_pkg::CAP_W-1:0] random_capacity();
        case ($urandom_range(5))
            0:       return 5'd0;
            1:       return 5'd1;
            2:       return 5'd16;
            3:       return 5'd31;
            4:       return 5'd17;
            default: return ldq_pkg::CAP_W'($urandom_range(31));
        endcase
    endfunction

    // Result checker. done is a one-cycle strobe with no back-pressure, so
    // every strobe sampled at an edge is one result.
    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with none pending: status %0d removed %0h",
                         $time, status, removed_item);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, status);
                    mismatch_count++;
                end
                if (removed_item !== want.removed)
                begin
                    $display("%0t: removed_item expected %0h actual %0h",
                             $time, want.removed, removed_item);
                    mismatch_count++;
                end
            end
        end
    end

    // Present one request and hold it until accepted (start && !busy at an
    // edge). After the accept, each following cycle is idle with the drawn
    // chance; start is assigned at most once per step.
    task automatic send_request(input logic [ldq_pkg::ACT_W-1:0]  op,
                                input logic [ldq_pkg::DATA_W-1:0] word);
        start  <= 1'b1;
        action <= op;
        item   <= word;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(predict_deque_op(op, word));
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Drop start and let every outstanding result come back.
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Capacity is only written with the deque idle.
    task automatic set_capacity(input logic [ldq_pkg::CAP_W-1:0] cap);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid       <= 1'b0;
        shadow_capacity  = cap;
    endtask

    // Deletes on a fresh, empty queue underflow at both ends.
    task automatic test_underflow_on_empty();
        send_request(ldq_pkg::ACT_DEL_FRONT, random_word());
        send_request(ldq_pkg::ACT_DEL_REAR, random_word());
    endtask

    // Front insert into an empty queue, refused front insert at front 0,
    // front insert into the hole left by a front delete, and the index
    // reset once the queue drains.
    task automatic test_front_insert_rules();
        send_request(ldq_pkg::ACT_INS_FRONT, 32'h8000_0000);
        send_request(ldq_pkg::ACT_INS_FRONT, 32'h7fff_ffff);
        send_request(ldq_pkg::ACT_INS_REAR, 32'h7fff_ffff);
        send_request(ldq_pkg::ACT_INS_REAR, 32'hffff_ffff);
        send_request(ldq_pkg::ACT_DEL_FRONT, '0);
        send_request(ldq_pkg::ACT_INS_FRONT, 32'h5555_5555);
        send_request(ldq_pkg::ACT_DEL_REAR, '0);
        send_request(ldq_pkg::ACT_DEL_REAR, '0);
        send_request(ldq_pkg::ACT_DEL_FRONT, '0);
        send_request(ldq_pkg::ACT_DEL_REAR, '0);
        send_request(ldq_pkg::ACT_INS_FRONT, 32'haaaa_aaaa);
        send_request(ldq_pkg::ACT_DEL_FRONT, '0);
    endtask

    // Zero capacity behaves as one, full queue refuses, raising and then
    // lowering capacity under a filled queue; it ends by writing the top code.
    task automatic test_capacity_limits();
        set_capacity(5'd0);
        send_request(ldq_pkg::ACT_INS_REAR, random_word());
        send_request(ldq_pkg::ACT_INS_REAR, random_word());
        set_capacity(5'd2);
        send_request(ldq_pkg::ACT_INS_REAR, random_word());
        send_request(ldq_pkg::ACT_INS_REAR, random_word());
        set_capacity(5'd1);
        send_request(ldq_pkg::ACT_INS_REAR, random_word());
        send_request(ldq_pkg::ACT_DEL_REAR, random_word());
        send_request(ldq_pkg::ACT_DEL_REAR, random_word());
        send_request(ldq_pkg::ACT_DEL_FRONT, random_word());
        set_capacity(5'd31);
    endtask

    // Random traffic in segments, each with its own capacity. Insert bias
    // flips every 23 requests so the queue swings between full and empty.
    task automatic test_random_traffic(input int idle_pct, input int per_segment);
        int                        insert_pct;
        logic [ldq_pkg::ACT_W-1:0] op;
        sender_idle_pct = idle_pct;
        for (int seg = 0; seg < 4; seg++)
        begin
            set_capacity(random_capacity());
            for (int n = 0; n < per_segment; n++)
            begin
                insert_pct = ((n / 23) % 2 == 0) ? 75 : 25;
                if ($urandom_range(99) < insert_pct)
                    op = ($urandom_range(3) == 0) ? ldq_pkg::ACT_INS_FRONT
                                                  : ldq_pkg::ACT_INS_REAR;
                else
                    op = $urandom_range(1) ? ldq_pkg::ACT_DEL_FRONT
                                           : ldq_pkg::ACT_DEL_REAR;
                send_request(op, random_word());
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_underflow_on_empty();
        test_front_insert_rules();
        test_capacity_limits();
        test_random_traffic(15, 92);
        test_random_traffic(69, 92);
        test_random_traffic(0, 92);

        wait_idle();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
